### rtl/core/nca_pkg.sv
package nca_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;
  localparam int DIST_W     = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTROID_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT_SQ = 2'd2;

  localparam logic [4:0]        CENTROID_COUNT_RST = 5'd16;
  localparam logic [7:0]        DIMENSIONS_RST     = 8'd2;
  // 1000.0 squared in q32.16
  localparam logic [DIST_W-1:0] LIMIT_RST          = 48'd65536000000;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_POINT = 1'b1
  } req_type_t;

  typedef struct packed {
    logic               req_type;
    logic [3:0]         centroid_index;
    logic [6:0]         dim_index;
    logic signed [15:0] coord_value;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [3:0]        nearest_index;
    logic [DIST_W-1:0] distance_sq;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic issue;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic point_use;
    logic count_zero;
    logic issue_last;
    logic pipe_busy;
    logic last_dim;
    logic out_free;
  } status_t;

endpackage

### rtl/core/nca_ctrl.sv
module nca_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  nca_pkg::status_t status,
  output nca_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.take  = in_valid && !in_stall_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.take && status.point_use) begin
          state_nxt = status.count_zero ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (status.issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // only the last coordinate of a point produces a result
        if (!status.last_dim) begin
          state_nxt = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    in_stall_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall = in_stall_r;

endmodule

### rtl/core/nca_dp.sv
module nca_dp #(
  parameter int MAX_CENTROIDS = 16,
  parameter int MAX_DIMS      = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [nca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nca_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  nca_pkg::in_item_t                in_payload,
  output logic                             out_valid,
  input  logic                             out_stall,
  output nca_pkg::out_item_t               out_payload,
  input  nca_pkg::cmd_t                    cmd,
  output nca_pkg::status_t                 status
);

  localparam int NSTORE = MAX_CENTROIDS * MAX_DIMS;
  localparam int AW     = (NSTORE > 1) ? $clog2(NSTORE) : 1;
  localparam int CW     = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int CNTW   = $clog2(MAX_CENTROIDS + 1);
  localparam int DW     = $clog2(MAX_DIMS + 1);
  localparam int DSW    = nca_pkg::DIST_W;

  // configuration
  logic [4:0]     cnt_r;
  logic [7:0]     dims_r;
  logic [DSW-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= nca_pkg::CENTROID_COUNT_RST;
      dims_r  <= nca_pkg::DIMENSIONS_RST;
      limit_r <= nca_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nca_pkg::CFG_CENTROID_COUNT:    cnt_r   <= cfg_wdata[4:0];
        nca_pkg::CFG_DIMENSIONS:        dims_r  <= cfg_wdata[7:0];
        nca_pkg::CFG_DISTANCE_LIMIT_SQ: limit_r <= cfg_wdata[DSW-1:0];
        default: ;
      endcase
    end
  end

  logic [CNTW-1:0] count_eff;
  logic [DW-1:0]   dims_eff;

  always_comb begin
    if (32'(cnt_r) > MAX_CENTROIDS) begin
      count_eff = CNTW'(MAX_CENTROIDS);
    end else begin
      count_eff = CNTW'(cnt_r);
    end
    if (dims_r == 8'd0) begin
      dims_eff = DW'(1);
    end else if (32'(dims_r) > MAX_DIMS) begin
      dims_eff = DW'(MAX_DIMS);
    end else begin
      dims_eff = DW'(dims_r);
    end
  end

  // request classification
  logic          is_point, point_use, in_last, load_ok, dim_zero;
  logic [AW-1:0] load_addr;

  assign is_point  = (in_payload.req_type == nca_pkg::REQ_POINT);
  assign point_use = is_point && (32'(in_payload.dim_index) < 32'(dims_eff));
  assign in_last   = (32'(in_payload.dim_index) == 32'(dims_eff) - 32'd1);
  assign dim_zero  = (in_payload.dim_index == 7'd0);
  assign load_ok   = !is_point
                     && (32'(in_payload.centroid_index) < MAX_CENTROIDS)
                     && (32'(in_payload.dim_index) < MAX_DIMS);
  assign load_addr = AW'(32'(in_payload.centroid_index) * MAX_DIMS
                         + 32'(in_payload.dim_index));

  // issue stage
  logic [CW-1:0]     j_r;
  logic [AW-1:0]     addr_r;
  logic signed [15:0] coord_r;
  logic              last_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      j_r     <= '0;
      addr_r  <= AW'(in_payload.dim_index);
      coord_r <= in_payload.coord_value;
      last_r  <= in_last;
    end else if (cmd.issue) begin
      j_r    <= j_r + CW'(1);
      addr_r <= addr_r + AW'(MAX_DIMS);
    end
  end

  // centroid store and accumulator memories
  logic [15:0]    store_mem [NSTORE];
  logic [DSW-1:0] acc_mem [MAX_CENTROIDS];
  logic [MAX_CENTROIDS-1:0] acc_vld_r;

  logic [15:0]    cdat_r;
  logic [DSW-1:0] acc_rd_r;
  logic           s1_ok_r;
  logic [CW-1:0]  s1_j_r, s2_j_r, s3_j_r;
  logic           s1_v_r, s2_v_r, s3_v_r;

  logic [15:0]    mag_r;
  logic [DSW-1:0] base2_r, base3_r;
  logic [31:0]    sq_r;

  logic [DSW:0]   sum;
  logic [DSW-1:0] sat;

  assign sum = {1'b0, base3_r} + {{(DSW + 1 - 32){1'b0}}, sq_r};
  assign sat = sum[DSW] ? {DSW{1'b1}} : sum[DSW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.take && load_ok) begin
      store_mem[load_addr] <= in_payload.coord_value;
    end
    cdat_r <= store_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (s3_v_r) begin
      acc_mem[s3_j_r] <= sat;
    end
    acc_rd_r <= acc_mem[j_r];
  end

  // an entry without its valid bit reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
    end else if (cmd.take && point_use && dim_zero) begin
      acc_vld_r <= '0;
    end else if (s3_v_r) begin
      acc_vld_r[s3_j_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  logic signed [16:0] diff;
  logic        [16:0] mag17;

  assign diff  = {coord_r[15], coord_r} - {cdat_r[15], cdat_r};
  assign mag17 = diff[16] ? (~diff + 17'd1) : diff;

  always_ff @(posedge clk) begin
    s1_ok_r <= acc_vld_r[j_r];
    s1_j_r  <= j_r;
    // difference magnitude never exceeds 16 bits
    mag_r   <= mag17[15:0];
    base2_r <= s1_ok_r ? acc_rd_r : '0;
    s2_j_r  <= s1_j_r;
    sq_r    <= mag_r * mag_r;
    base3_r <= base2_r;
    s3_j_r  <= s2_j_r;
  end

  // running minimum, strict compare keeps the lowest index on ties
  logic           found_r;
  logic [CW-1:0]  best_j_r;
  logic [DSW-1:0] best_d_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      found_r  <= 1'b0;
      best_j_r <= '0;
      best_d_r <= limit_r;
    end else if (s3_v_r && last_r && (sat < best_d_r)) begin
      found_r  <= 1'b1;
      best_j_r <= s3_j_r;
      best_d_r <= sat;
    end
  end

  // output register
  logic               out_valid_r;
  nca_pkg::out_item_t out_payload_r;
  logic [31:0]        best_j32;

  assign best_j32 = 32'(best_j_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_payload_r.found         <= found_r;
      out_payload_r.nearest_index <= found_r ? best_j32[3:0] : 4'd0;
      out_payload_r.distance_sq   <= found_r ? best_d_r : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  always_comb begin
    status            = '0;
    status.point_use  = point_use;
    status.count_zero = (count_eff == '0);
    status.issue_last = ((32'(j_r) + 32'd1) == 32'(count_eff));
    status.pipe_busy  = s1_v_r || s2_v_r || s3_v_r;
    status.last_dim   = last_r;
    status.out_free   = !out_valid_r || !out_stall;
  end

endmodule

### rtl/core/nearest_centroid_assign_core.sv
// centroid load request: written to the store at the edge that accepts it; the input does not stall after a load
// point coordinate request in use: the input stays stalled while the single read port of the
// centroid store is walked one centroid per cycle and the s1 to s3 stages drain
// last coordinate of a point: result registered in the finish state, held off while the output is stalled
// synchronous active-low reset restores the register defaults and clears the accumulator
// valid bits so the sums read as zero; the centroid store is not cleared and needs no clearing pass
module nearest_centroid_assign_core #(
  parameter int MAX_CENTROIDS = 16,
  parameter int MAX_DIMS      = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [nca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nca_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  nca_pkg::in_item_t              in_payload,
  output logic                           out_valid,
  input  logic                           out_stall,
  output nca_pkg::out_item_t             out_payload
);

  nca_pkg::cmd_t    cmd;
  nca_pkg::status_t status;

  nca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  nca_dp #(
    .MAX_CENTROIDS (MAX_CENTROIDS),
    .MAX_DIMS      (MAX_DIMS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

### rtl/core/nca_checker.sv
module nca_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input nca_pkg::in_item_t  in_payload,
  input logic               out_valid,
  input logic               out_stall,
  input nca_pkg::out_item_t out_payload
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  // centroid loads never block the input
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_payload.req_type == nca_pkg::REQ_LOAD) |=> !in_stall)
    else $error("input stalled after a centroid load");

  // a result only appears after the block was busy with a point
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // not found carries zero index and distance
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.found |->
      (out_payload.nearest_index == 4'd0) && (out_payload.distance_sq == '0))
    else $error("not found result with nonzero fields");

endmodule

bind nearest_centroid_assign_core nca_checker u_nca_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_payload  (in_payload),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_payload (out_payload)
);

### verif/nca_assign_checker.sv
`timescale 1ns / 1ps

module nca_assign_checker
  import nca_pkg::*;
#(
  parameter int MAX_CENTROIDS = 16,
  parameter int MAX_DIMS      = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_payload,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_payload,
  output int                    mismatches,
  output int                    pending,
  output int                    assignments,
  output int                    hits
);

  localparam logic [DIST_W-1:0] DIST_SAT = '1;

  logic signed [15:0] coord_store [MAX_CENTROIDS][MAX_DIMS];
  logic [DIST_W-1:0]  dist_acc [MAX_CENTROIDS];
  logic [4:0]         count_reg;
  logic [7:0]         dims_reg;
  logic [DIST_W-1:0]  limit_reg;
  out_item_t          assign_q [$];

  initial begin
    mismatches  = 0;
    pending     = 0;
    assignments = 0;
    hits        = 0;
  end

  // stores a load, folds a point coordinate into the sums, queues a result on the last one
  task automatic score_request(input in_item_t req);
    int                dims_eff;
    int                count_eff;
    int                dim;
    int                diff;
    logic [63:0]       mag;
    logic [63:0]       sum;
    logic [DIST_W-1:0] best_d;
    out_item_t         res;
    dim = int'(req.dim_index);
    if (req.req_type == REQ_LOAD) begin
      if (int'(req.centroid_index) < MAX_CENTROIDS && dim < MAX_DIMS)
        coord_store[req.centroid_index][dim] = req.coord_value;
      return;
    end
    dims_eff = (dims_reg == 8'd0) ? 1 : int'(dims_reg);
    if (dims_eff > MAX_DIMS) dims_eff = MAX_DIMS;
    if (dim >= dims_eff) return;
    count_eff = int'(count_reg);
    if (count_eff > MAX_CENTROIDS) count_eff = MAX_CENTROIDS;
    if (dim == 0) begin
      for (int j = 0; j < MAX_CENTROIDS; j++) dist_acc[j] = '0;
    end
    for (int j = 0; j < count_eff; j++) begin
      diff = int'($signed(req.coord_value)) - int'(coord_store[j][dim]);
      mag  = 64'((diff < 0) ? -diff : diff);
      sum  = {16'b0, dist_acc[j]} + mag * mag;
      dist_acc[j] = (sum > {16'b0, DIST_SAT}) ? DIST_SAT : sum[DIST_W-1:0];
    end
    if (dim != dims_eff - 1) return;
    res    = '0;
    best_d = limit_reg;
    // strict compare keeps the lowest index on ties
    for (int j = 0; j < count_eff; j++) begin
      if (dist_acc[j] < best_d) begin
        best_d            = dist_acc[j];
        res.found         = 1'b1;
        res.nearest_index = 4'(j);
        res.distance_sq   = best_d;
      end
    end
    assign_q.push_back(res);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      count_reg = CENTROID_COUNT_RST;
      dims_reg  = DIMENSIONS_RST;
      limit_reg = LIMIT_RST;
      for (int j = 0; j < MAX_CENTROIDS; j++) dist_acc[j] = '0;
      assign_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        assignments++;
        if (out_payload.found) hits++;
        if (assign_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing pending, got found=%0d index=%0d dist=%0d",
                   $time, out_payload.found, out_payload.nearest_index,
                   out_payload.distance_sq);
        end else begin
          want = assign_q.pop_front();
          if (out_payload.found !== want.found) begin
            mismatches++;
            $display("%0t: found expected %0d got %0d", $time, want.found, out_payload.found);
          end
          if (out_payload.nearest_index !== want.nearest_index) begin
            mismatches++;
            $display("%0t: nearest_index expected %0d got %0d", $time, want.nearest_index,
                     out_payload.nearest_index);
          end
          if (out_payload.distance_sq !== want.distance_sq) begin
            mismatches++;
            $display("%0t: distance_sq expected %0d got %0d", $time, want.distance_sq,
                     out_payload.distance_sq);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTROID_COUNT:    count_reg = cfg_wdata[4:0];
          CFG_DIMENSIONS:        dims_reg  = cfg_wdata[7:0];
          CFG_DISTANCE_LIMIT_SQ: limit_reg = cfg_wdata[DIST_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) score_request(in_payload);
    end
    pending = assign_q.size();
  end

endmodule

### verif/tb_nearest_centroid_assign_core.sv
`timescale 1ns / 1ps

module tb_nearest_centroid_assign_core;
  import nca_pkg::*;

  localparam int NUM_CENTROIDS   = 16;
  localparam int NUM_DIMS        = 128;
  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 32;
  localparam int TARGET_REQUESTS = 800;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [DIST_W-1:0]    LIMIT_MAX  = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_payload;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_payload;

  int mismatches;
  int pending;
  int assignments;
  int hits;

  int idle_pct  = 29;
  int stall_pct = 29;
  bit hold_now  = 1'b0;
  int quiet     = 0;
  int dims_eff  = 2;
  int cnt_eff   = 16;
  int sent      = 0;
  int settings  = 1;

  bit                 loaded [NUM_CENTROIDS][NUM_DIMS];
  logic signed [15:0] mirror [NUM_CENTROIDS][NUM_DIMS];

  nearest_centroid_assign_core #(
    .MAX_CENTROIDS(NUM_CENTROIDS),
    .MAX_DIMS     (NUM_DIMS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_payload(out_payload)
  );

  nca_assign_checker #(
    .MAX_CENTROIDS(NUM_CENTROIDS),
    .MAX_DIMS     (NUM_DIMS)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_payload(out_payload),
    .mismatches (mismatches),
    .pending    (pending),
    .assignments(assignments),
    .hits       (hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stall, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_now) begin
        hold_now = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2, 3, 4: return 16'($urandom_range(16)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_request(input in_item_t req);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, ($urandom_range(3) == 0) ? 24 : 3);
      repeat (gap) @(posedge clk);
    end
    in_payload <= req;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic load_coord(input int c, input int d, input logic signed [15:0] v);
    in_item_t req;
    req.req_type       = REQ_LOAD;
    req.centroid_index = 4'(c);
    req.dim_index      = 7'(d);
    req.coord_value    = v;
    push_request(req);
    loaded[c][d] = 1'b1;
    mirror[c][d] = v;
  endtask

  task automatic point_coord(input int d, input logic signed [15:0] v);
    in_item_t req;
    req.req_type       = REQ_POINT;
    req.centroid_index = 4'($urandom);
    req.dim_index      = 7'(d);
    req.coord_value    = v;
    push_request(req);
  endtask

  // every centroid in use needs each coordinate in use loaded before a point reads it
  task automatic fill_store();
    for (int c = 0; c < cnt_eff; c++)
      for (int d = 0; d < dims_eff; d++)
        if (!loaded[c][d]) load_coord(c, d, pick_coord());
  endtask

  task automatic send_point();
    int  t;
    bit  near;
    logic signed [15:0] v;
    t    = (cnt_eff > 0) ? $urandom_range(cnt_eff - 1) : 0;
    near = (cnt_eff > 0) && ($urandom_range(2) == 0);
    for (int d = 0; d < dims_eff; d++) begin
      v = near ? mirror[t][d] + 16'($urandom_range(6)) - 16'sd3 : pick_coord();
      point_coord(d, v);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do repeat (SETTLE_CYCLES) @(posedge clk); while (pending != 0);
  endtask

  task automatic program_regs(input int count, input int dims, input logic [DIST_W-1:0] limit,
                              input bit poke_unused);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CENTROID_COUNT;
    cfg_wdata <= CFG_DATA_W'(count);
    @(posedge clk);
    cfg_index <= CFG_DIMENSIONS;
    cfg_wdata <= CFG_DATA_W'(dims);
    @(posedge clk);
    cfg_index <= CFG_DISTANCE_LIMIT_SQ;
    cfg_wdata <= limit;
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_wdata <= CFG_DATA_W'({$urandom, $urandom});
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    dims_eff = (dims == 0) ? 1 : ((dims > NUM_DIMS) ? NUM_DIMS : dims);
    cnt_eff  = (count > NUM_CENTROIDS) ? NUM_CENTROIDS : count;
    settings++;
    fill_store();
  endtask

  function automatic logic [DIST_W-1:0] tuned_limit(input int dims);
    return (DIST_W'($urandom) * DIST_W'(dims)) >> $urandom_range(24);
  endfunction

  // mostly whole points, the rest loads, stray coordinates and partial points
  task automatic run_traffic(input int budget);
    int done;
    int kind;
    int first;
    int last;
    done = 0;
    while (done < budget) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        send_point();
        done += dims_eff;
      end else if (kind < 80) begin
        load_coord($urandom_range(NUM_CENTROIDS - 1), $urandom_range(NUM_DIMS - 1),
                   pick_coord());
        done++;
      end else if (kind < 90 && dims_eff < NUM_DIMS) begin
        point_coord($urandom_range(dims_eff, NUM_DIMS - 1), pick_coord());
      end else begin
        first = $urandom_range(dims_eff - 1);
        last  = $urandom_range(first, dims_eff - 1);
        for (int d = first; d <= last; d++) point_coord(d, pick_coord());
        done += last - first + 1;
      end
    end
  endtask

  initial begin
    int count;
    int dims;
    logic [DIST_W-1:0] limit;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_payload = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: two coordinates, all sixteen centroids
    fill_store();
    load_coord(0, 0, 16'sh8000);
    load_coord(15, 1, 16'sh7fff);
    load_coord(15, NUM_DIMS - 1, 16'sh8000);
    // centroids 3 and 7 coincide, the lower one must win
    load_coord(3, 0, 16'sh0100);
    load_coord(3, 1, 16'sh0100);
    load_coord(7, 0, 16'sh0100);
    load_coord(7, 1, 16'sh0100);
    point_coord(0, 16'sh0100);
    point_coord(1, 16'sh0100);
    point_coord(0, 16'sh8000);
    point_coord(1, 16'sh7fff);
    point_coord(0, 16'sh7fff);
    point_coord(1, 16'sh8000);
    // past the last coordinate: ignored
    point_coord(2, pick_coord());
    point_coord(NUM_DIMS - 1, pick_coord());
    // last coordinate on stale sums, then a restarted point
    point_coord(1, pick_coord());
    point_coord(0, pick_coord());
    point_coord(0, pick_coord());
    point_coord(1, pick_coord());
    settle();

    // one centroid, one coordinate: every point request on coordinate zero yields a result
    program_regs(1, 1, LIMIT_MAX, 1'b0);
    hold_now = 1'b1;
    run_traffic(100);
    settle();

    // no centroid in use
    program_regs(0, 3, LIMIT_RST, 1'b1);
    run_traffic(40);
    settle();

    // count clamps to sixteen, zero dimensions acts as one, nothing below a zero limit
    program_regs(31, 0, '0, 1'b0);
    run_traffic(40);
    settle();

    // widest points with no idling on either side
    idle_pct  = 0;
    stall_pct = 0;
    program_regs(2, NUM_DIMS, LIMIT_MAX, 1'b0);
    run_traffic(NUM_DIMS);
    settle();
    idle_pct  = 29;
    stall_pct = 29;

    program_regs(2, 255, tuned_limit(NUM_DIMS), 1'b0);
    run_traffic(NUM_DIMS);
    settle();

    while (sent < TARGET_REQUESTS) begin
      count = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, NUM_CENTROIDS);
      dims  = ($urandom_range(4) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      case ($urandom_range(3))
        0:       limit = LIMIT_RST;
        3:       limit = DIST_W'({$urandom, $urandom});
        default: limit = tuned_limit(dims);
      endcase
      program_regs(count, dims, limit, 1'($urandom_range(1)));
      run_traffic(60);
      settle();
    end

    $display("%0d requests under %0d register settings, long hold-off and idle-free stretch",
             sent, settings);
    $display("%0d assignments checked, %0d found a centroid below the limit", assignments, hits);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/nca_pkg.sv
rtl/core/nca_ctrl.sv
rtl/core/nca_dp.sv
rtl/core/nearest_centroid_assign_core.sv
rtl/core/nca_checker.sv
verif/nca_assign_checker.sv
verif/tb_nearest_centroid_assign_core.sv
